// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock while out of reset
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// consequent checked in the clock after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/pichb_pkg.sv =====
// shared constants, codes and controller/datapath interface types
`default_nettype none

package pichb_pkg;

  // moving average depth default and shutdown count
  localparam int unsigned AVG_DEPTH_DEF  = 4;
  localparam int unsigned SHUTDOWN_TICKS = 400;

  // field widths
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned POT_W      = 12;
  localparam int unsigned CUR_W      = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned MAG_W      = 15;
  localparam int unsigned DUTY_W     = 16;
  localparam int unsigned HP_W       = 16;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned INTEG_W    = 32;
  localparam int unsigned ERR_W      = CUR_W + 1;
  localparam int unsigned CMAG_W     = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // remainder unit: two quotient bits per step
  localparam int unsigned DIV_STEPS = HP_W / 2;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // request kinds
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;

  // result actions
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_HALT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SET  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_MAG     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_SPAN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_WRAP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_LOW    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE_HIGH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 3'd7;

  // register reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 16'd32768;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = 16'd6554;
  localparam logic [MAG_W-1:0]  REF_MAG_RST     = 15'd100;
  localparam logic [DUTY_W-1:0] DUTY_SPAN_RST   = 16'd1200;
  localparam logic [DUTY_W-1:0] PWM_WRAP_RST    = 16'd65535;
  localparam logic [POT_W-1:0]  SAFE_LOW_RST    = 12'd3800;
  localparam logic [POT_W-1:0]  SAFE_HIGH_RST   = 12'd4000;
  localparam logic [HP_W-1:0]   HALF_PERIOD_RST = 16'd100;

  // commands from controller to datapath
  typedef struct packed {
    logic             take;
    logic             ring;
    logic             avg_mul;
    logic             avg_set;
    logic             cmd_apply;
    logic             shut;
    logic             div_init;
    logic             div_step;
    logic             err_step;
    logic             integ_step;
    logic             mul_step;
    logic             sum_step;
    logic             scale_step;
    logic             load_out;
    logic [ACT_W-1:0] act;
  } pichb_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              enabled;
    logic              win_bad;
    logic              shut_hit;
    logic              div_last;
  } pichb_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pichb_dp.sv =====
// datapath: pot average, tick state, flip remainder, PI arithmetic, result register
`default_nettype none

module pichb_dp #(
  parameter int unsigned AVG_DEPTH = pichb_pkg::AVG_DEPTH_DEF
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  pichb_pkg::pichb_cmd_t                  cmd_i,
  output pichb_pkg::pichb_stat_t                 stat_o,
  input  wire        [pichb_pkg::KIND_W-1:0]     kind_i,
  input  wire        [pichb_pkg::POT_W-1:0]      pot_sample_i,
  input  wire signed [pichb_pkg::CUR_W-1:0]      current_sample_i,
  input  wire                                    cfg_we_i,
  input  wire        [pichb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire        [pichb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic       [pichb_pkg::ACT_W-1:0]      action_o,
  output logic       [pichb_pkg::DUTY_W-1:0]     duty_a_o,
  output logic       [pichb_pkg::DUTY_W-1:0]     duty_b_o,
  output logic       [pichb_pkg::POT_W-1:0]      pot_average_o
);
  import pichb_pkg::*;

  // ring index and sum widths, reciprocal for the average
  localparam int unsigned IDX_W   = $clog2(AVG_DEPTH);
  localparam int unsigned SUM_W   = POT_W + IDX_W;
  localparam int unsigned AVG_S   = SUM_W + IDX_W;
  localparam int unsigned AVG_M   = ((2 ** AVG_S) + AVG_DEPTH - 1) / AVG_DEPTH;
  localparam int unsigned AVG_M_W = SUM_W + 1;
  localparam int unsigned APROD_W = SUM_W + AVG_M_W;
  localparam int unsigned PTERM_W = GAIN_W + 1 + ERR_W;
  localparam int unsigned ITERM_W = GAIN_W + 1 + INTEG_W;
  localparam int unsigned C_W     = ITERM_W + 1;
  localparam int unsigned DPROD_W = CMAG_W + DUTY_W;

  localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(AVG_DEPTH - 1);
  localparam logic [AVG_M_W-1:0] AVG_MUL  = AVG_M_W'(AVG_M);
  localparam logic [TICK_W-1:0]  SHUT_CNT = TICK_W'(SHUTDOWN_TICKS);
  localparam logic [CMAG_W-1:0]  C_UNIT   = CMAG_W'(65536);

  // one restoring remainder bit
  function automatic logic [HP_W-1:0] rem_bit(input logic [HP_W-1:0] r, input logic b,
                                              input logic [HP_W-1:0] d);
    logic [HP_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[HP_W-1:0];
  endfunction

  // configuration registers
  logic [GAIN_W-1:0] prop_gain_q, integ_gain_q;
  logic [MAG_W-1:0]  ref_mag_q;
  logic [DUTY_W-1:0] duty_span_q, pwm_wrap_q;
  logic [POT_W-1:0]  safe_low_q, safe_high_q;
  logic [HP_W-1:0]   half_period_q;

  // latched request
  logic [KIND_W-1:0]       kind_q;
  logic [POT_W-1:0]        pot_q;
  logic signed [CUR_W-1:0] cur_q;

  // controller state held in the datapath
  logic [POT_W-1:0]          ring_q [AVG_DEPTH];
  logic [SUM_W-1:0]          sum_q, sum_d;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic [APROD_W-1:0]        aprod_q;
  logic [POT_W-1:0]          avg_q;
  logic [TICK_W-1:0]         tick_q, tick_d;
  logic                      enabled_q, enabled_d;
  logic                      dir_neg_q, dir_neg_d;
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [INTEG_W-1:0] integ_d_sel;

  // remainder unit
  logic [HP_W-1:0]      dvd_q, rem_q, rem1, rem2;
  logic [DIV_CNT_W-1:0] cnt_q;

  // PI pipeline registers
  logic signed [ERR_W-1:0]   err_q, err_d;
  logic signed [PTERM_W-1:0] pterm_q;
  logic signed [ITERM_W-1:0] iterm_q;
  logic [CMAG_W-1:0]         cmag_q, cmag_d;
  logic [CMAG_W-1:0]         delta_q;

  logic                      flip, dir_new;
  logic signed [ERR_W-1:0]   ref_s;
  logic signed [INTEG_W:0]   isum;
  logic signed [C_W-1:0]     c_sum, c_neg;
  logic [DPROD_W-1:0]        dprod;
  logic [DUTY_W-1:0]         duty;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= PROP_GAIN_RST;
      integ_gain_q  <= INTEG_GAIN_RST;
      ref_mag_q     <= REF_MAG_RST;
      duty_span_q   <= DUTY_SPAN_RST;
      pwm_wrap_q    <= PWM_WRAP_RST;
      safe_low_q    <= SAFE_LOW_RST;
      safe_high_q   <= SAFE_HIGH_RST;
      half_period_q <= HALF_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PROP_GAIN:   prop_gain_q   <= cfg_data_i[GAIN_W-1:0];
        REG_INTEG_GAIN:  integ_gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_REF_MAG:     ref_mag_q     <= cfg_data_i[MAG_W-1:0];
        REG_DUTY_SPAN:   duty_span_q   <= cfg_data_i[DUTY_W-1:0];
        REG_PWM_WRAP:    pwm_wrap_q    <= cfg_data_i[DUTY_W-1:0];
        REG_SAFE_LOW:    safe_low_q    <= cfg_data_i[POT_W-1:0];
        REG_SAFE_HIGH:   safe_high_q   <= cfg_data_i[POT_W-1:0];
        REG_HALF_PERIOD: half_period_q <= cfg_data_i[HP_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_TICK;
    end else if (cmd_i.take) begin
      kind_q <= kind_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      pot_q <= pot_sample_i;
      cur_q <= current_sample_i;
    end
  end

  // ring slot replace and running sum
  always_comb begin
    sum_d = sum_q - SUM_W'(ring_q[idx_q]) + SUM_W'(pot_q);
    idx_d = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      sum_q <= '0;
      idx_q <= '0;
      avg_q <= '0;
    end else begin
      if (cmd_i.ring) begin
        ring_q[idx_q] <= pot_q;
        sum_q         <= sum_d;
        idx_q         <= idx_d;
      end
      if (cmd_i.avg_set) begin
        avg_q <= aprod_q[AVG_S +: POT_W];
      end
    end
  end

  // divide by depth as multiply by reciprocal
  always_ff @(posedge clk_i) begin
    if (cmd_i.avg_mul) begin
      aprod_q <= APROD_W'(sum_q) * APROD_W'(AVG_MUL);
    end
  end

  // reference flip and error
  always_comb begin
    flip    = (half_period_q != '0) && (rem_q == '0);
    dir_new = dir_neg_q ^ flip;
    ref_s   = dir_new ? -$signed({2'b00, ref_mag_q}) : $signed({2'b00, ref_mag_q});
    err_d   = ref_s - $signed({cur_q[CUR_W-1], cur_q});
  end

  // saturating integral
  always_comb begin
    isum = $signed({integ_q[INTEG_W-1], integ_q})
         + $signed({{(INTEG_W + 1 - ERR_W){err_q[ERR_W-1]}}, err_q});
    if (isum[INTEG_W] != isum[INTEG_W-1]) begin
      integ_d = isum[INTEG_W] ? $signed({1'b1, {(INTEG_W-1){1'b0}}})
                              : $signed({1'b0, {(INTEG_W-1){1'b1}}});
    end else begin
      integ_d = isum[INTEG_W-1:0];
    end
  end

  // tick, enable, direction and integral updates
  always_comb begin
    tick_d      = tick_q;
    enabled_d   = enabled_q;
    dir_neg_d   = dir_neg_q;
    integ_d_sel = integ_q;
    priority if (cmd_i.ring) begin
      tick_d = tick_q + 1'b1;
    end else if (cmd_i.cmd_apply) begin
      enabled_d   = (kind_q == KIND_START);
      integ_d_sel = '0;
    end else if (cmd_i.shut) begin
      tick_d      = '0;
      enabled_d   = 1'b0;
      dir_neg_d   = 1'b0;
      integ_d_sel = '0;
    end else if (cmd_i.err_step) begin
      dir_neg_d = dir_new;
    end else if (cmd_i.integ_step) begin
      integ_d_sel = integ_d;
    end else begin
      tick_d = tick_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      enabled_q <= 1'b0;
      dir_neg_q <= 1'b1;
      integ_q   <= '0;
    end else begin
      tick_q    <= tick_d;
      enabled_q <= enabled_d;
      dir_neg_q <= dir_neg_d;
      integ_q   <= integ_d_sel;
    end
  end

  // remainder of tick count by half period, two bits per step
  always_comb begin
    rem1 = rem_bit(rem_q, dvd_q[HP_W-1], half_period_q);
    rem2 = rem_bit(rem1, dvd_q[HP_W-2], half_period_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dvd_q <= tick_q[HP_W-1:0];
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[HP_W-3:0], 2'b00};
      rem_q <= rem2;
    end
  end

  // control value clamp to the unit range of the active direction
  always_comb begin
    c_sum = $signed({{(C_W - PTERM_W){pterm_q[PTERM_W-1]}}, pterm_q})
          + $signed({iterm_q[ITERM_W-1], iterm_q});
    c_neg = -c_sum;
    if (dir_neg_q) begin
      if (!c_sum[C_W-1]) begin
        cmag_d = '0;
      end else if (c_neg[C_W-2:0] > (C_W-1)'(C_UNIT)) begin
        cmag_d = C_UNIT;
      end else begin
        cmag_d = c_neg[CMAG_W-1:0];
      end
    end else begin
      if (c_sum[C_W-1]) begin
        cmag_d = '0;
      end else if (c_sum[C_W-2:0] > (C_W-1)'(C_UNIT)) begin
        cmag_d = C_UNIT;
      end else begin
        cmag_d = c_sum[CMAG_W-1:0];
      end
    end
  end

  assign dprod = DPROD_W'(cmag_q) * DPROD_W'(duty_span_q);

  // PI pipeline
  always_ff @(posedge clk_i) begin
    if (cmd_i.err_step) begin
      err_q <= err_d;
    end
    if (cmd_i.mul_step) begin
      pterm_q <= $signed({1'b0, prop_gain_q}) * err_q;
      iterm_q <= $signed({1'b0, integ_gain_q}) * integ_q;
    end
    if (cmd_i.sum_step) begin
      cmag_q <= cmag_d;
    end
    if (cmd_i.scale_step) begin
      delta_q <= dprod[DPROD_W-1:DUTY_W];
    end
  end

  // active channel duty, floored at zero
  assign duty = (delta_q > {1'b0, pwm_wrap_q}) ? '0 : pwm_wrap_q - delta_q[DUTY_W-1:0];

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      action_o      <= cmd_i.act;
      pot_average_o <= avg_q;
      if (cmd_i.act == ACT_SET) begin
        duty_a_o <= dir_neg_q ? duty : pwm_wrap_q;
        duty_b_o <= dir_neg_q ? pwm_wrap_q : duty;
      end else begin
        duty_a_o <= '0;
        duty_b_o <= '0;
      end
    end
  end

  // status to controller
  always_comb begin
    stat_o.kind     = kind_q;
    stat_o.enabled  = enabled_q;
    stat_o.win_bad  = (avg_q < safe_low_q) || (avg_q > safe_high_q);
    stat_o.shut_hit = (tick_q >= SHUT_CNT);
    stat_o.div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pichb_ctrl.sv =====
// controller: sequences one request through the datapath and owns the handshakes
`default_nettype none

module pichb_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  input  pichb_pkg::pichb_stat_t  stat_i,
  output pichb_pkg::pichb_cmd_t   cmd_o
);
  import pichb_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_DEC   = 12'b0000_0000_0010,
    ST_AMUL  = 12'b0000_0000_0100,
    ST_ASET  = 12'b0000_0000_1000,
    ST_CHECK = 12'b0000_0001_0000,
    ST_DIV   = 12'b0000_0010_0000,
    ST_ERR   = 12'b0000_0100_0000,
    ST_INTEG = 12'b0000_1000_0000,
    ST_MUL   = 12'b0001_0000_0000,
    ST_SUM   = 12'b0010_0000_0000,
    ST_SCALE = 12'b0100_0000_0000,
    ST_DONE  = 12'b1000_0000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [ACT_W-1:0] act_q, act_d;
  logic             out_valid_q, out_valid_d;

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    cmd_o   = '0;
    cmd_o.act = act_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_DEC;
        end
      end
      ST_DEC: begin
        act_d = ACT_NONE;
        unique case (stat_i.kind)
          KIND_TICK: begin
            cmd_o.ring = 1'b1;
            state_d    = ST_AMUL;
          end
          KIND_START, KIND_STOP: begin
            cmd_o.cmd_apply = 1'b1;
            state_d         = ST_DONE;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_AMUL: begin
        cmd_o.avg_mul = 1'b1;
        state_d       = ST_ASET;
      end
      ST_ASET: begin
        cmd_o.avg_set = 1'b1;
        state_d       = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (!stat_i.enabled) begin
          act_d   = ACT_NONE;
          state_d = ST_DONE;
        end else if (stat_i.win_bad) begin
          act_d   = ACT_HALT;
          state_d = ST_DONE;
        end else if (stat_i.shut_hit) begin
          cmd_o.shut = 1'b1;
          act_d      = ACT_HALT;
          state_d    = ST_DONE;
        end else begin
          cmd_o.div_init = 1'b1;
          act_d          = ACT_SET;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd_o.err_step = 1'b1;
        state_d        = ST_INTEG;
      end
      ST_INTEG: begin
        cmd_o.integ_step = 1'b1;
        state_d          = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        state_d        = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_step = 1'b1;
        state_d        = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale_step = 1'b1;
        state_d          = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result slot: filled on load, emptied when taken
  assign out_valid_d = cmd_o.load_out | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      act_q       <= ACT_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pi_current_controller_hbridge.sv =====
// PI current controller for an H-bridge with pot moving average, top level
// Each request is a tick (pot and current samples) or a start or stop command, and
// gives exactly one result. A tick can end early (disabled, outside the pot window,
// or at the shutdown count); a full PI tick first computes the sign-flip remainder
// of the tick count by half_period, two bits per cycle, followed by steps for the
// error, the saturating integral, the two gain multiplies, the clamp and the duty
// scaling. A new request is taken while the previous result still waits in the
// output register. Configuration writes are always ready and must only be issued
// while no request is in flight.
`default_nettype none

module pi_current_controller_hbridge #(
  parameter int unsigned AVG_DEPTH = pichb_pkg::AVG_DEPTH_DEF
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_stall_o,
  input  wire        [pichb_pkg::KIND_W-1:0]     kind_i,
  input  wire        [pichb_pkg::POT_W-1:0]      pot_sample_i,
  input  wire signed [pichb_pkg::CUR_W-1:0]      current_sample_i,
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output logic       [pichb_pkg::ACT_W-1:0]      action_o,
  output logic       [pichb_pkg::DUTY_W-1:0]     duty_a_o,
  output logic       [pichb_pkg::DUTY_W-1:0]     duty_b_o,
  output logic       [pichb_pkg::POT_W-1:0]      pot_average_o,
  input  wire                                    cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire        [pichb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire        [pichb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pichb_pkg::*;

  pichb_cmd_t  cmd;
  pichb_stat_t stat;

  // register writes land in the next cycle
  assign cfg_ready_o = 1'b1;

  pichb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pichb_dp #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .kind_i           (kind_i),
    .pot_sample_i     (pot_sample_i),
    .current_sample_i (current_sample_i),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .action_o         (action_o),
    .duty_a_o         (duty_a_o),
    .duty_b_o         (duty_b_o),
    .pot_average_o    (pot_average_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/pichb_chk.sv =====
// port-level checker for the controller top, attached by bind
`default_nettype none

`include "assert_macros.svh"

module pichb_chk (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               in_valid_i,
  input wire                               in_stall_o,
  input wire                               out_valid_o,
  input wire                               out_stall_i,
  input wire        [pichb_pkg::ACT_W-1:0]  action_o,
  input wire        [pichb_pkg::DUTY_W-1:0] duty_a_o,
  input wire        [pichb_pkg::DUTY_W-1:0] duty_b_o,
  input wire        [pichb_pkg::POT_W-1:0]  pot_average_o
);
  import pichb_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_o & ~out_stall_i;

  // requests taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // busy right after taking a request
  `ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_acc, in_stall_o)

  // every result answers a request
  `ASSERT_RST(a_no_spurious_result, clk_i, rst_ni, !out_valid_o || pend_q != 2'd0)

  // only a duty update carries duties
  `ASSERT_RST(a_duty_zero, clk_i, rst_ni,
    !out_valid_o || action_o == ACT_SET || (duty_a_o == '0 && duty_b_o == '0))

  // stalled result holds
  `ASSERT_NEXT(a_result_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(action_o) && $stable(duty_a_o) && $stable(duty_b_o)
    && $stable(pot_average_o))

endmodule

bind pi_current_controller_hbridge pichb_chk u_pichb_chk (.*);

`default_nettype wire

// ===== tb/pi_current_controller_hbridge_checker.sv =====
// result checker for the h-bridge pi current controller: predicts and compares every result
`timescale 1ns / 100ps

module pi_current_controller_hbridge_checker
  import pichb_pkg::*;
(
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  input  wire                         in_stall_i,
  input  wire        [KIND_W-1:0]     kind_i,
  input  wire        [POT_W-1:0]      pot_sample_i,
  input  wire signed [CUR_W-1:0]      current_sample_i,
  input  wire                         out_valid_i,
  input  wire                         out_stall_i,
  input  wire        [ACT_W-1:0]      action_i,
  input  wire        [DUTY_W-1:0]     duty_a_i,
  input  wire        [DUTY_W-1:0]     duty_b_i,
  input  wire        [POT_W-1:0]      pot_average_i,
  input  wire                         cfg_valid_i,
  input  wire                         cfg_ready_i,
  input  wire        [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire        [CFG_DATA_W-1:0] cfg_data_i,
  output logic       [31:0]           pending_o,
  output logic       [31:0]           fail_count_o
);

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [POT_W-1:0]  avg;
  } ctl_result_t;

  localparam longint INTEG_MAX = 64'sd2147483647;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam longint UNIT      = 64'sd65536;

  // register copies
  logic [GAIN_W-1:0] prop_gain;
  logic [GAIN_W-1:0] integ_gain;
  logic [MAG_W-1:0]  ref_mag;
  logic [DUTY_W-1:0] duty_span;
  logic [DUTY_W-1:0] pwm_wrap;
  logic [POT_W-1:0]  safe_low;
  logic [POT_W-1:0]  safe_high;
  logic [HP_W-1:0]   half_period;

  // controller state copy
  logic [POT_W-1:0]         pot_ring [AVG_DEPTH_DEF];
  int unsigned              pot_sum;
  int unsigned              ring_idx;
  logic                     enabled;
  logic [TICK_W-1:0]        tick_count;
  logic                     dir_neg;
  logic signed [INTEG_W-1:0] integ_acc;

  ctl_result_t expected_results [$];
  int unsigned mismatch_cnt;

  // one request through the controller, returns the result it should give
  function automatic ctl_result_t compute_control(input logic [KIND_W-1:0] kind,
                                                  input logic [POT_W-1:0] pot,
                                                  input logic signed [CUR_W-1:0] cur);
    ctl_result_t res;
    logic [POT_W-1:0] avg;
    longint err;
    longint integ_sum;
    longint ctl;
    longint delta;
    longint duty;
    res = '0;
    res.action = ACT_NONE;
    if (kind == KIND_START || kind == KIND_STOP) begin
      enabled = (kind == KIND_START);
      integ_acc = '0;
    end else if (kind == KIND_TICK) begin
      tick_count = tick_count + 1;
      pot_sum = pot_sum - pot_ring[ring_idx] + pot;
      pot_ring[ring_idx] = pot;
      ring_idx = (ring_idx + 1) % AVG_DEPTH_DEF;
      avg = pot_sum / AVG_DEPTH_DEF;
      if (!enabled) begin
        res.action = ACT_NONE;
      end else if (avg < safe_low || avg > safe_high) begin
        res.action = ACT_HALT;
      end else if (tick_count >= SHUTDOWN_TICKS) begin
        res.action = ACT_HALT;
        tick_count = '0;
        enabled = 1'b0;
        integ_acc = '0;
        dir_neg = 1'b0;
      end else begin
        // reference sign flip, zero half period never flips
        if (half_period != 0 && tick_count % half_period == 0) dir_neg = !dir_neg;
        err = (dir_neg ? -longint'(ref_mag) : longint'(ref_mag)) - longint'(cur);
        integ_sum = longint'(integ_acc) + err;
        if (integ_sum > INTEG_MAX) integ_sum = INTEG_MAX;
        if (integ_sum < INTEG_MIN) integ_sum = INTEG_MIN;
        integ_acc = integ_sum;
        ctl = longint'(prop_gain) * err + longint'(integ_gain) * integ_sum;
        // clamp to the unit range of the active direction
        if (dir_neg) begin
          if (ctl > 0) ctl = 0;
          if (ctl < -UNIT) ctl = -UNIT;
          ctl = -ctl;
        end else begin
          if (ctl < 0) ctl = 0;
          if (ctl > UNIT) ctl = UNIT;
        end
        delta = (ctl * longint'(duty_span)) >>> 16;
        duty = (delta > longint'(pwm_wrap)) ? 0 : longint'(pwm_wrap) - delta;
        res.duty_a = dir_neg ? duty[DUTY_W-1:0] : pwm_wrap;
        res.duty_b = dir_neg ? pwm_wrap : duty[DUTY_W-1:0];
        res.action = ACT_SET;
      end
    end
    res.avg = pot_sum / AVG_DEPTH_DEF;
    return res;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%t: %s", $realtime, msg);
  endtask

  // watch the three channels
  always @(posedge clk_i or negedge rst_ni) begin : watch
    ctl_result_t got;
    ctl_result_t want;
    if (!rst_ni) begin
      prop_gain   = PROP_GAIN_RST;
      integ_gain  = INTEG_GAIN_RST;
      ref_mag     = REF_MAG_RST;
      duty_span   = DUTY_SPAN_RST;
      pwm_wrap    = PWM_WRAP_RST;
      safe_low    = SAFE_LOW_RST;
      safe_high   = SAFE_HIGH_RST;
      half_period = HALF_PERIOD_RST;
      for (int i = 0; i < AVG_DEPTH_DEF; i++) pot_ring[i] = '0;
      pot_sum    = 0;
      ring_idx   = 0;
      enabled    = 1'b0;
      tick_count = '0;
      dir_neg    = 1'b1;
      integ_acc  = '0;
      expected_results.delete();
      mismatch_cnt = 0;
      pending_o    <= '0;
      fail_count_o <= '0;
    end else begin
      // register writes, masked to register width
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_PROP_GAIN:   prop_gain   = cfg_data_i[GAIN_W-1:0];
          REG_INTEG_GAIN:  integ_gain  = cfg_data_i[GAIN_W-1:0];
          REG_REF_MAG:     ref_mag     = cfg_data_i[MAG_W-1:0];
          REG_DUTY_SPAN:   duty_span   = cfg_data_i[DUTY_W-1:0];
          REG_PWM_WRAP:    pwm_wrap    = cfg_data_i[DUTY_W-1:0];
          REG_SAFE_LOW:    safe_low    = cfg_data_i[POT_W-1:0];
          REG_SAFE_HIGH:   safe_high   = cfg_data_i[POT_W-1:0];
          REG_HALF_PERIOD: half_period = cfg_data_i[HP_W-1:0];
          default: ;
        endcase
      end
      // results are compared before this edge's request is predicted
      if (out_valid_i && !out_stall_i) begin
        got = '{action_i, duty_a_i, duty_b_i, pot_average_i};
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result: action %0d duty_a %0d duty_b %0d avg %0d",
                                 got.action, got.duty_a, got.duty_b, got.avg));
        end else begin
          want = expected_results.pop_front();
          if (got.action !== want.action || got.duty_a !== want.duty_a ||
              got.duty_b !== want.duty_b || got.avg !== want.avg)
            note_failure($sformatf({"mismatch: expected action %0d duty_a %0d duty_b %0d ",
                                    "avg %0d, got action %0d duty_a %0d duty_b %0d avg %0d"},
                                   want.action, want.duty_a, want.duty_b, want.avg,
                                   got.action, got.duty_a, got.duty_b, got.avg));
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(compute_control(kind_i, pot_sample_i, current_sample_i));
      pending_o    <= expected_results.size();
      fail_count_o <= mismatch_cnt;
    end
  end

endmodule

// ===== tb/pi_current_controller_hbridge_tb.sv =====
// testbench top for the h-bridge pi current controller: stimulus, idling and verdict
`timescale 1ns / 100ps

module pi_current_controller_hbridge_tb;
  import pichb_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int STALL_LIMIT     = 3000;
  localparam int END_PAUSE       = 40;

  logic                    clk_i            = 1'b0;
  logic                    rst_ni           = 1'b0;
  logic                    in_valid_i       = 1'b0;
  logic [KIND_W-1:0]       kind_i           = KIND_TICK;
  logic [POT_W-1:0]        pot_sample_i     = '0;
  logic signed [CUR_W-1:0] current_sample_i = '0;
  logic                    out_stall_i      = 1'b0;
  logic                    cfg_valid_i      = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i      = REG_PROP_GAIN;
  logic [CFG_DATA_W-1:0]   cfg_data_i       = '0;

  logic                    in_stall_o;
  logic                    out_valid_o;
  logic [ACT_W-1:0]        action_o;
  logic [DUTY_W-1:0]       duty_a_o;
  logic [DUTY_W-1:0]       duty_b_o;
  logic [POT_W-1:0]        pot_average_o;
  logic                    cfg_ready_o;

  logic [31:0]             pending_results;
  logic [31:0]             fail_total;

  int                      send_idle_pct = 26;
  int                      recv_idle_pct = 88;
  logic [POT_W-1:0]        win_lo = SAFE_LOW_RST;
  logic [POT_W-1:0]        win_hi = SAFE_HIGH_RST;
  int                      mag_now = REF_MAG_RST;
  int unsigned             idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  pi_current_controller_hbridge uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .pot_sample_i     (pot_sample_i),
    .current_sample_i (current_sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .action_o         (action_o),
    .duty_a_o         (duty_a_o),
    .duty_b_o         (duty_b_o),
    .pot_average_o    (pot_average_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  pi_current_controller_hbridge_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .kind_i           (kind_i),
    .pot_sample_i     (pot_sample_i),
    .current_sample_i (current_sample_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .action_i         (action_o),
    .duty_a_i         (duty_a_o),
    .duty_b_i         (duty_b_o),
    .pot_average_i    (pot_average_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .pending_o        (pending_results),
    .fail_count_o     (fail_total)
  );

  // receiver stalls at random
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99, 0) < recv_idle_pct);

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("pi_current_controller_hbridge_tb NOT OK");
      $finish;
    end
  end

  // one request, with random idle cycles ahead of it
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POT_W-1:0] pot,
                              input logic signed [CUR_W-1:0] cur);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    kind_i           <= kind;
    pot_sample_i     <= pot;
    current_sample_i <= cur;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // full register set, written only while no request is in flight
  task automatic configure(input logic [15:0] pg, ig, mag, span, wrap, lo, hi, hp);
    write_reg(REG_PROP_GAIN, pg);
    write_reg(REG_INTEG_GAIN, ig);
    write_reg(REG_REF_MAG, mag);
    write_reg(REG_DUTY_SPAN, span);
    write_reg(REG_PWM_WRAP, wrap);
    write_reg(REG_SAFE_LOW, lo);
    write_reg(REG_SAFE_HIGH, hi);
    write_reg(REG_HALF_PERIOD, hp);
    cfg_valid_i <= 1'b0;
    win_lo  = lo[POT_W-1:0];
    win_hi  = hi[POT_W-1:0];
    mag_now = mag[MAG_W-1:0];
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  // mostly in-window ticks, a few commands and unused kinds
  task automatic send_random();
    int unsigned pick;
    logic [KIND_W-1:0] kind;
    logic [POT_W-1:0] pot;
    logic signed [CUR_W-1:0] cur;
    pick = $urandom_range(99, 0);
    if (pick < 6) kind = KIND_START;
    else if (pick < 8) kind = KIND_STOP;
    else if (pick < 10) kind = KIND_UNUSED;
    else kind = KIND_TICK;
    if (win_lo <= win_hi && $urandom_range(9, 0) != 0) pot = $urandom_range(win_hi, win_lo);
    else pot = $urandom_range(4095, 0);
    pick = $urandom_range(9, 0);
    if (pick < 3) cur = $urandom_range(65535, 0);
    else if (pick < 6) cur = int'($urandom_range(600, 0)) - 300;
    else cur = ($urandom_range(1, 0) ? mag_now : -mag_now) + int'($urandom_range(6, 0)) - 3;
    send_request(kind, pot, cur);
  endtask

  initial begin : stimulus
    int unsigned lo;
    int unsigned hi;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part on reset settings
    send_request(KIND_UNUSED, 12'd4095, -16'sd32768);
    send_request(KIND_TICK, 12'd0, 16'sd32767);         // disabled tick
    send_request(KIND_STOP, 12'd4095, 16'sd0);
    send_request(KIND_START, 12'd0, 16'sd0);
    send_request(KIND_TICK, 12'd3900, 16'sd0);          // average still below window
    send_request(KIND_TICK, 12'd3900, -16'sd32768);
    send_request(KIND_TICK, 12'd3900, 16'sd32767);
    send_request(KIND_TICK, 12'd3900, -16'sd100);       // first pi step
    send_request(KIND_TICK, 12'd4095, 16'sd100);
    send_request(KIND_TICK, 12'd3800, -16'sd99);
    send_request(KIND_TICK, 12'd3800, -16'sd101);
    send_request(KIND_TICK, 12'd3800, 16'sd32767);
    send_request(KIND_TICK, 12'd3800, -16'sd32768);     // average on the low edge
    send_request(KIND_TICK, 12'd4000, -16'sd100);
    send_request(KIND_TICK, 12'd4000, 16'sd0);
    send_request(KIND_TICK, 12'd4000, -16'sd200);
    send_request(KIND_TICK, 12'd4000, 16'sd5);          // average on the high edge
    send_request(KIND_TICK, 12'd4095, 16'sd0);          // above window
    send_request(KIND_STOP, 12'd0, 16'sd0);
    send_request(KIND_TICK, 12'd4000, 16'sd0);
    send_request(KIND_START, 12'd2730, 16'sd21845);
    send_request(KIND_TICK, 12'd1365, -16'sd21846);
    drain();

    // random phases, each with its own register set, idling set per pair of phases
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: configure(PROP_GAIN_RST, INTEG_GAIN_RST, REF_MAG_RST, DUTY_SPAN_RST,
                     PWM_WRAP_RST, SAFE_LOW_RST, SAFE_HIGH_RST, HALF_PERIOD_RST);
        1: begin
          lo = $urandom_range(2000, 0);
          hi = $urandom_range(4095, lo);
          configure($urandom_range(65535, 0), $urandom_range(8000, 0),
                    $urandom_range(2000, 0), $urandom_range(65535, 0),
                    $urandom_range(65535, 1), lo, hi, $urandom_range(150, 1));
        end
        // upper extremes, reserved bits set, duty underflow and flip on every tick
        2: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 16'd1);
        // lower extremes, zero half period never flips
        3: configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hF000, 16'd4095, 16'd0);
        // inverted window halts every enabled tick
        4: configure($urandom_range(65535, 0), $urandom_range(65535, 0),
                     $urandom_range(32767, 0), $urandom_range(65535, 0),
                     $urandom_range(65535, 1), 16'd3000, 16'd1000, $urandom_range(400, 1));
        default: begin
          lo = $urandom_range(4000, 0);
          hi = lo + $urandom_range(95, 0);
          configure($urandom_range(65535, 0), $urandom_range(20000, 0),
                    $urandom_range(32767, 0), $urandom_range(65535, 0),
                    $urandom_range(65535, 1), lo, hi, $urandom_range(65535, 1));
        end
      endcase
      case (phase / 2)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_random();
      drain();
    end

    repeat (END_PAUSE) @(posedge clk_i);
    if (fail_total == 0)
      $display("pi_current_controller_hbridge_tb OK");
    else
      $display("pi_current_controller_hbridge_tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/pichb_pkg.sv
hw/rtl/pichb_dp.sv
hw/rtl/pichb_ctrl.sv
hw/rtl/pi_current_controller_hbridge.sv
hw/rtl/pichb_chk.sv
tb/pi_current_controller_hbridge_checker.sv
tb/pi_current_controller_hbridge_tb.sv
